### sv/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared codes, limits and the interval entry type of the tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned MAX_INTERVALS = 16;
  localparam int unsigned MAX_FRAGMENT  = 65535;

  localparam logic [31:0] LIMIT16 = 32'h0000_ffff;
  localparam logic [31:0] LIMIT32 = 32'hffff_ffff;

  typedef enum logic [1:0] {
    MODE_SETUP = 2'd0,
    MODE_DATA  = 2'd1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OC_RUNNING  = 2'd0,
    OC_COMPLETE = 2'd1,
    OC_FAILED   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [31:0] start;
    logic [32:0] stop;
  } entry_t;

  typedef struct packed {
    logic start_le_off;
    logic start_le_ne;
    logic stop_ge_off;
    logic stop_gt_ne;
  } cmp_t;

endpackage

### sv/frt_mem.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker interval memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frt_mem #(
  parameter int unsigned Depth = frt_pkg::MAX_INTERVALS,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  frt_pkg::entry_t wdata_i,
  input  logic [Aw-1:0]   raddr_i,
  output frt_pkg::entry_t rdata_o
);

  frt_pkg::entry_t mem_q [Depth];
  frt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/frt_cmp.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker compare unit
// Compares one interval entry against the fragment offset and the running
// merged end; shared by the scan, merge and setup steps.
// ----------------------------------------------------------------------------
module frt_cmp (
  input  frt_pkg::entry_t ent_i,
  input  logic [31:0]     off_i,
  input  logic [32:0]     ne_i,
  output frt_pkg::cmp_t   res_o
);

  always_comb begin
    res_o.start_le_off = ent_i.start <= off_i;
    res_o.start_le_ne  = {1'b0, ent_i.start} <= ne_i;
    res_o.stop_ge_off  = ent_i.stop >= {1'b0, off_i};
    res_o.stop_gt_ne   = ent_i.stop > ne_i;
  end

endmodule

### sv/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Keeps a sorted table of received byte intervals, the declared object size
// and a sticky outcome, and reports which part of each fragment to store.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_wide_offsets_i
//   in       in         in_valid_i/in_ready_o   mode, offset, length, size
//   out      out        out_valid_o/out_ready_i status, store, outcome, count
//
// A data item scans the table an entry at a time, moves entries if needed and
// writes the merged entry; a setup item checks the size and the last entry. The
// single memory port and the shared compare unit keep these steps in sequence.
// Reset clears the count, size and outcome at once. A result waiting on
// out_ready_i stalls only the final step of the next item.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
  parameter int unsigned MaxIntervals = frt_pkg::MAX_INTERVALS,
  parameter int unsigned MaxFragment  = frt_pkg::MAX_FRAGMENT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_wide_offsets_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] frag_offset_i,
  input  logic [15:0] frag_length_i,
  input  logic [31:0] size_minus_one_i,
  input  logic        empty_object_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [32:0] store_from_o,
  output logic [15:0] store_length_o,
  output logic [1:0]  outcome_o,
  output logic [4:0]  ranges_held_o
);

  localparam int unsigned AW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int unsigned CW = $clog2(MaxIntervals + 1);
  localparam logic [32:0] Bound16 = 33'(frt_pkg::LIMIT16) + 33'd1;
  localparam logic [32:0] Bound32 = 33'(frt_pkg::LIMIT32) + 33'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_A,
    S_MERGE,
    S_SCAN_B,
    S_SIZE,
    S_MOVE,
    S_PLACE,
    S_SETUP,
    S_SETUP_END,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       n_q;
  logic [32:0]         exp_q;
  logic                known_q;
  frt_pkg::outcome_e   final_q;
  logic                wide_q;
  logic [31:0]         off_q;
  logic [15:0]         flen_q;
  logic [32:0]         fend_q;
  logic [31:0]         field_q;
  logic                empty_q;
  logic [32:0]         sz_q;
  logic [CW-1:0]       sc_q;
  logic                havep_q;
  frt_pkg::entry_t     pent_q;
  logic [CW-1:0]       lo_q;
  logic [CW-1:0]       hi_q;
  logic [31:0]         ns_q;
  logic [32:0]         ne_q;
  logic [32:0]         sfrom_q;
  logic [15:0]         len_q;
  logic [AW-1:0]       src_q;
  logic [AW-1:0]       dst_q;
  logic [AW-1:0]       delta_q;
  logic [CW-1:0]       cnt_q;
  logic                up_q;
  logic                pend_q;
  logic [CW:0]         newn_q;
  frt_pkg::status_e    status_q;
  logic                out_valid_q;
  frt_pkg::status_e    status_out_q;
  logic [32:0]         from_out_q;
  logic [15:0]         len_out_q;
  frt_pkg::outcome_e   outcome_out_q;
  logic [CW-1:0]       held_out_q;

  frt_pkg::entry_t     rd_data;
  frt_pkg::entry_t     cmp_ent;
  frt_pkg::cmp_t       cmp_res;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  frt_pkg::entry_t     wdata;

  logic                sc_lt_n;
  logic [CW-1:0]       sc_next;
  logic [CW-1:0]       nm1;
  logic                adv_a;
  logic                adv_b;
  logic                touch;
  logic [32:0]         fend_in;
  logic [32:0]         sz_in;
  logic                chk_bad;
  logic                setup_bad;
  logic [CW-1:0]       removed;
  logic [CW:0]         newn;
  logic [CW-1:0]       cnt_up;
  logic [CW-1:0]       cnt_dn;
  logic [CW-1:0]       cnt_sel;
  logic [32:0]         len_diff;
  logic                complete;
  logic                out_load;
  frt_pkg::outcome_e   final_next;

  frt_mem #(
    .Depth(MaxIntervals)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  frt_cmp u_cmp (
    .ent_i(cmp_ent),
    .off_i(off_q),
    .ne_i (ne_q),
    .res_o(cmp_res)
  );

  assign cmp_ent  = (state_q == S_MERGE) ? pent_q : rd_data;
  assign sc_lt_n  = sc_q < n_q;
  assign sc_next  = sc_q + 1'b1;
  assign nm1      = n_q - 1'b1;
  assign adv_a    = sc_lt_n && cmp_res.start_le_off;
  assign adv_b    = sc_lt_n && cmp_res.start_le_ne;
  assign touch    = havep_q && cmp_res.stop_ge_off;
  assign fend_in  = {1'b0, frag_offset_i} + {17'd0, frag_length_i};
  assign sz_in    = empty_object_i ? 33'd0 : ({1'b0, size_minus_one_i} + 33'd1);

  assign chk_bad = (flen_q == 16'd0) || (flen_q > 16'(MaxFragment)) ||
                   (known_q ? (fend_q > exp_q) : (fend_q > (wide_q ? Bound32 : Bound16)));
  assign setup_bad = (!wide_q && (field_q[31:16] != 16'd0)) ||
                     (empty_q && (field_q != 32'd0)) ||
                     (known_q && (sz_q != exp_q));

  assign removed  = hi_q - lo_q;
  assign newn     = {1'b0, n_q} - {1'b0, removed} + 1'b1;
  assign cnt_up   = n_q - lo_q;
  assign cnt_dn   = n_q - hi_q;
  assign cnt_sel  = (removed == '0) ? cnt_up : cnt_dn;
  assign len_diff = fend_q - sfrom_q;

  assign complete = known_q && ((exp_q == 33'd0) ||
                    ((n_q == CW'(1)) && (ns_q == 32'd0) && (ne_q == exp_q)));
  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    final_next = final_q;
    if (final_q == frt_pkg::OC_RUNNING) begin
      if (status_q != frt_pkg::ST_OK) begin
        final_next = frt_pkg::OC_FAILED;
      end else if (complete) begin
        final_next = frt_pkg::OC_COMPLETE;
      end
    end
  end

  always_comb begin
    case (state_q)
      S_SCAN_A: raddr = adv_a ? sc_next[AW-1:0] : sc_q[AW-1:0];
      S_MERGE:  raddr = sc_q[AW-1:0];
      S_SCAN_B: raddr = sc_next[AW-1:0];
      S_SETUP:  raddr = nm1[AW-1:0];
      S_MOVE:   raddr = src_q;
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    we    = ((state_q == S_MOVE) && pend_q) || (state_q == S_PLACE);
    waddr = (state_q == S_PLACE) ? lo_q[AW-1:0] : dst_q;
    if (state_q == S_PLACE) begin
      wdata.start = ns_q;
      wdata.stop  = ne_q;
    end else begin
      wdata = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      n_q           <= '0;
      exp_q         <= '0;
      known_q       <= 1'b0;
      final_q       <= frt_pkg::OC_RUNNING;
      wide_q        <= 1'b0;
      off_q         <= '0;
      flen_q        <= '0;
      fend_q        <= '0;
      field_q       <= '0;
      empty_q       <= 1'b0;
      sz_q          <= '0;
      sc_q          <= '0;
      havep_q       <= 1'b0;
      pent_q        <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      ns_q          <= '0;
      ne_q          <= '0;
      sfrom_q       <= '0;
      len_q         <= '0;
      src_q         <= '0;
      dst_q         <= '0;
      delta_q       <= '0;
      cnt_q         <= '0;
      up_q          <= 1'b0;
      pend_q        <= 1'b0;
      newn_q        <= '0;
      status_q      <= frt_pkg::ST_OK;
      out_valid_q   <= 1'b0;
      status_out_q  <= frt_pkg::ST_OK;
      from_out_q    <= '0;
      len_out_q     <= '0;
      outcome_out_q <= frt_pkg::OC_RUNNING;
      held_out_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        wide_q <= cfg_wide_offsets_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            off_q    <= frag_offset_i;
            flen_q   <= frag_length_i;
            fend_q   <= fend_in;
            field_q  <= size_minus_one_i;
            empty_q  <= empty_object_i;
            sz_q     <= sz_in;
            sfrom_q  <= '0;
            len_q    <= '0;
            if (mode_i == frt_pkg::MODE_SETUP) begin
              status_q <= frt_pkg::ST_OK;
              ne_q     <= sz_in;
              state_q  <= S_SETUP;
            end else if (mode_i == frt_pkg::MODE_DATA) begin
              status_q <= frt_pkg::ST_OK;
              ne_q     <= fend_in;
              state_q  <= S_CHECK;
            end else begin
              status_q <= frt_pkg::ST_UNKNOWN;
              state_q  <= S_FINISH;
            end
          end
        end
        S_CHECK: begin
          if (chk_bad) begin
            status_q <= frt_pkg::ST_INVALID;
            state_q  <= S_FINISH;
          end else begin
            sc_q    <= '0;
            havep_q <= 1'b0;
            state_q <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          if (adv_a) begin
            havep_q <= 1'b1;
            pent_q  <= rd_data;
            sc_q    <= sc_next;
          end else begin
            state_q <= S_MERGE;
          end
        end
        S_MERGE: begin
          lo_q    <= touch ? (sc_q - 1'b1) : sc_q;
          ns_q    <= touch ? pent_q.start : off_q;
          sfrom_q <= touch ? pent_q.stop : {1'b0, off_q};
          if (touch && cmp_res.stop_gt_ne) begin
            ne_q <= pent_q.stop;
          end
          state_q <= S_SCAN_B;
        end
        S_SCAN_B: begin
          if (adv_b) begin
            if (cmp_res.stop_gt_ne) begin
              ne_q <= rd_data.stop;
            end
            sc_q <= sc_next;
          end else begin
            hi_q    <= sc_q;
            state_q <= S_SIZE;
          end
        end
        S_SIZE: begin
          if (newn > (CW+1)'(MaxIntervals)) begin
            status_q <= frt_pkg::ST_FULL;
            state_q  <= S_FINISH;
          end else begin
            newn_q  <= newn;
            pend_q  <= 1'b0;
            cnt_q   <= cnt_sel;
            if (removed == '0) begin
              up_q  <= 1'b1;
              src_q <= nm1[AW-1:0];
            end else begin
              up_q    <= 1'b0;
              src_q   <= hi_q[AW-1:0];
              delta_q <= removed[AW-1:0] - 1'b1;
            end
            state_q <= (cnt_sel != '0) ? S_MOVE : S_PLACE;
          end
        end
        S_MOVE: begin
          if (cnt_q != '0) begin
            pend_q <= 1'b1;
            dst_q  <= up_q ? (src_q + 1'b1) : (src_q - delta_q);
            src_q  <= up_q ? (src_q - 1'b1) : (src_q + 1'b1);
            cnt_q  <= cnt_q - 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          n_q     <= newn_q[CW-1:0];
          len_q   <= (fend_q > sfrom_q) ? len_diff[15:0] : 16'd0;
          state_q <= S_FINISH;
        end
        S_SETUP: begin
          if (setup_bad) begin
            status_q <= frt_pkg::ST_INVALID;
            state_q  <= S_FINISH;
          end else begin
            if (!known_q) begin
              exp_q   <= sz_q;
              known_q <= 1'b1;
            end
            state_q <= S_SETUP_END;
          end
        end
        S_SETUP_END: begin
          if ((n_q != '0) && cmp_res.stop_gt_ne) begin
            status_q <= frt_pkg::ST_INVALID;
          end
          ns_q    <= rd_data.start;
          ne_q    <= rd_data.stop;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            final_q       <= final_next;
            out_valid_q   <= 1'b1;
            status_out_q  <= status_q;
            from_out_q    <= (status_q == frt_pkg::ST_OK) ? sfrom_q : 33'd0;
            len_out_q     <= (status_q == frt_pkg::ST_OK) ? len_q : 16'd0;
            outcome_out_q <= final_next;
            held_out_q    <= n_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_out_q;
  assign store_from_o   = from_out_q;
  assign store_length_o = len_out_q;
  assign outcome_o      = outcome_out_q;
  assign ranges_held_o  = 5'(held_out_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MaxIntervals))
    else $error("Interval count exceeds the table depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (final_q != frt_pkg::OC_RUNNING) |=> (final_q == $past(final_q)))
    else $error("Outcome changed after it was settled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && out_load && (status_q != frt_pkg::ST_OK)) |=>
      (final_q != frt_pkg::OC_RUNNING))
    else $error("An error item left the outcome running.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(known_q))
    else $error("Declared size was lost.");

endmodule

### sim/fragment_reassembly_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Sends setup, data and unknown items into the tracker with random stalls on
// both channels, keeps an interval table of its own alongside the block and
// checks every result against it through several offset-width settings.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_test;

  localparam logic [1:0] MODE_RESERVED_A = 2'd2;
  localparam logic [1:0] MODE_RESERVED_B = 2'd3;
  localparam int SETTLE_CYCLES = 2 * frt_pkg::MAX_INTERVALS + 16;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] offset;
    logic [15:0] length;
    logic [31:0] size_m1;
    logic        empty;
  } frag_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [32:0] store_from;
    logic [15:0] store_len;
    logic [1:0]  outcome;
    logic [4:0]  held;
  } track_result_t;

  class interval_ledger;
    bit [31:0]          run_lo[frt_pkg::MAX_INTERVALS];
    bit [32:0]          run_hi[frt_pkg::MAX_INTERVALS];
    int                 held;
    bit [32:0]          obj_size;
    bit                 size_set;
    bit                 wide;
    frt_pkg::outcome_e  verdict;
    track_result_t      due[$];
    int unsigned        failures;

    function new();
      held = 0;
      obj_size = '0;
      size_set = 1'b0;
      wide = 1'b0;
      verdict = frt_pkg::OC_RUNNING;
      failures = 0;
    endfunction

    function bit [32:0] fend_cap();
      if (size_set) return obj_size;
      return wide ? 33'h1_0000_0000 : 33'h0_0001_0000;
    endfunction

    function frt_pkg::status_e apply_setup(frag_item_t it);
      bit [32:0] sz;
      if (!wide && it.size_m1 > frt_pkg::LIMIT16) return frt_pkg::ST_INVALID;
      if (it.empty) begin
        if (it.size_m1 != 0) return frt_pkg::ST_INVALID;
        sz = '0;
      end else begin
        sz = {1'b0, it.size_m1} + 33'd1;
      end
      if (size_set) begin
        if (sz != obj_size) return frt_pkg::ST_INVALID;
      end else begin
        obj_size = sz;
        size_set = 1'b1;
      end
      if (held > 0 && run_hi[held - 1] > sz) return frt_pkg::ST_INVALID;
      return frt_pkg::ST_OK;
    endfunction

    function frt_pkg::status_e apply_fragment(frag_item_t it, output bit [32:0] from,
                                              output bit [15:0] len);
      bit [32:0] fend;
      bit [32:0] merged_lo;
      bit [32:0] merged_hi;
      bit [32:0] keep_to;
      bit        joins;
      int        p;
      int        lo;
      int        hi;
      int        gone;
      int        after;
      int        i;
      from = '0;
      len = '0;
      if (it.length == 0 || it.length > frt_pkg::MAX_FRAGMENT) return frt_pkg::ST_INVALID;
      fend = {1'b0, it.offset} + 33'(it.length);
      if (fend > fend_cap()) return frt_pkg::ST_INVALID;
      p = -1;
      for (i = 0; i < held; i++) begin
        if (run_lo[i] <= it.offset) p = i;
      end
      joins = 1'b0;
      if (p >= 0) joins = run_hi[p] >= {1'b0, it.offset};
      merged_hi = fend;
      if (joins) begin
        lo = p;
        merged_lo = run_lo[p];
        keep_to = run_hi[p];
        if (run_hi[p] > merged_hi) merged_hi = run_hi[p];
      end else begin
        lo = p + 1;
        merged_lo = it.offset;
        keep_to = it.offset;
      end
      hi = p + 1;
      while (hi < held && run_lo[hi] <= merged_hi) begin
        if (run_hi[hi] > merged_hi) merged_hi = run_hi[hi];
        hi++;
      end
      gone = hi - lo;
      after = held - gone + 1;
      if (after > int'(frt_pkg::MAX_INTERVALS)) return frt_pkg::ST_FULL;
      if (gone == 0) begin
        for (i = held; i > lo; i--) begin
          run_lo[i] = run_lo[i - 1];
          run_hi[i] = run_hi[i - 1];
        end
      end else begin
        for (i = hi; i < held; i++) begin
          run_lo[i - gone + 1] = run_lo[i];
          run_hi[i - gone + 1] = run_hi[i];
        end
      end
      run_lo[lo] = merged_lo[31:0];
      run_hi[lo] = merged_hi;
      held = after;
      from = keep_to;
      len = (fend > keep_to) ? 16'(fend - keep_to) : 16'd0;
      return frt_pkg::ST_OK;
    endfunction

    function void note_item(frag_item_t it);
      track_result_t      r;
      frt_pkg::status_e   st;
      bit [32:0]          from;
      bit [15:0]          len;
      from = '0;
      len = '0;
      case (it.mode)
        frt_pkg::MODE_SETUP: st = apply_setup(it);
        frt_pkg::MODE_DATA:  st = apply_fragment(it, from, len);
        default:             st = frt_pkg::ST_UNKNOWN;
      endcase
      if (st != frt_pkg::ST_OK) begin
        from = '0;
        len = '0;
      end
      if (verdict == frt_pkg::OC_RUNNING) begin
        if (st != frt_pkg::ST_OK) begin
          verdict = frt_pkg::OC_FAILED;
        end else if (size_set && (obj_size == 0 || (held == 1 && run_lo[0] == 0 &&
                                                     run_hi[0] == obj_size))) begin
          verdict = frt_pkg::OC_COMPLETE;
        end
      end
      r.status = st;
      r.store_from = from;
      r.store_len = len;
      r.outcome = verdict;
      r.held = 5'(held);
      due.push_back(r);
    endfunction

    function void check_result(logic [1:0] got_status, logic [32:0] got_from,
                               logic [15:0] got_len, logic [1:0] got_outcome,
                               logic [4:0] got_held);
      track_result_t exp;
      if (due.size() == 0) begin
        $error("result arrived with no item pending");
        failures++;
        return;
      end
      exp = due.pop_front();
      if (got_status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got_status);
        failures++;
      end
      if (got_from !== exp.store_from) begin
        $error("store_from: expected %0h, got %0h", exp.store_from, got_from);
        failures++;
      end
      if (got_len !== exp.store_len) begin
        $error("store_length: expected %0d, got %0d", exp.store_len, got_len);
        failures++;
      end
      if (got_outcome !== exp.outcome) begin
        $error("outcome: expected %0d, got %0d", exp.outcome, got_outcome);
        failures++;
      end
      if (got_held !== exp.held) begin
        $error("ranges_held: expected %0d, got %0d", exp.held, got_held);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_wide_offsets_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [31:0] frag_offset_i;
  logic [15:0] frag_length_i;
  logic [31:0] size_minus_one_i;
  logic        empty_object_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [32:0] store_from_o;
  logic [15:0] store_length_o;
  logic [1:0]  outcome_o;
  logic [4:0]  ranges_held_o;

  interval_ledger ledger = new();
  int             tx_gap_pct;
  bit             rx_steady;

  fragment_reassembly_tracker i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_wide_offsets_i (cfg_wide_offsets_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .frag_offset_i      (frag_offset_i),
    .frag_length_i      (frag_length_i),
    .size_minus_one_i   (size_minus_one_i),
    .empty_object_i     (empty_object_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .store_from_o       (store_from_o),
    .store_length_o     (store_length_o),
    .outcome_o          (outcome_o),
    .ranges_held_o      (ranges_held_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check_result(status_o, store_from_o, store_length_o, outcome_o, ranges_held_o);
    end
  end

  initial begin
    int left;
    int pct;
    int span;
    left = 0;
    pct = 0;
    span = 0;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span = $urandom_range(50, 300);
        pct = ($urandom_range(0, 1) == 0) ? 0 : 20;
      end
      span--;
      if (left == 0 && !rx_steady && $urandom_range(0, 99) < pct) left = $urandom_range(1, 12);
      if (left > 0) begin
        left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic frag_item_t spec_item(logic [1:0] mode, logic [31:0] offset,
                                           logic [15:0] length, logic [31:0] size_m1,
                                           logic empty);
    frag_item_t it;
    it.mode = mode;
    it.offset = offset;
    it.length = length;
    it.size_m1 = size_m1;
    it.empty = empty;
    return it;
  endfunction

  function automatic frag_item_t blank_item(logic [1:0] mode);
    return spec_item(mode, $urandom, 16'($urandom), $urandom, 1'($urandom));
  endfunction

  function automatic frag_item_t pick_fragment();
    frag_item_t      it;
    longint unsigned cap;
    longint unsigned lo_b;
    longint unsigned hi_b;
    longint unsigned off;
    longint unsigned len;
    longint unsigned stop;
    longint unsigned back;
    int              k;
    int              roll;
    int              held;
    int              bridge_pct;
    it = blank_item(frt_pkg::MODE_DATA);
    cap = ledger.fend_cap();
    held = ledger.held;
    bridge_pct = (held >= 12) ? 45 : 15;
    roll = $urandom_range(0, 99);
    if (held >= 2 && roll < bridge_pct) begin
      k = $urandom_range(0, held - 2);
      back = $urandom_range(0, 16);
      if (back > ledger.run_hi[k] - ledger.run_lo[k]) back = 0;
      off = ledger.run_hi[k] - back;
      stop = ledger.run_lo[k + 1] + $urandom_range(0, 16);
      len = stop - off;
      if (len == 0 || len > 65535) len = $urandom_range(1, 65535);
    end else if (held >= 1 && roll < 60) begin
      k = $urandom_range(0, held - 1);
      off = ledger.run_lo[k] +
            longint'($urandom) % (ledger.run_hi[k] - ledger.run_lo[k] + 1);
      len = $urandom_range(1, 512);
    end else if (roll < 90) begin
      k = $urandom_range(0, held);
      lo_b = (k == 0) ? 0 : ledger.run_hi[k - 1];
      hi_b = (k == held) ? cap : ledger.run_lo[k];
      off = lo_b;
      if (hi_b > lo_b) off += longint'($urandom) % ((hi_b - lo_b > 2048) ? 2048 : hi_b - lo_b);
      len = $urandom_range(1, 256);
    end else if (roll < 95) begin
      off = (cap > 300) ? cap - $urandom_range(1, 300) : 0;
      len = $urandom_range(1, 600);
    end else begin
      off = $urandom;
      len = $urandom_range(1, 65535);
    end
    it.offset = (off > 32'hffff_ffff) ? 32'hffff_ffff : 32'(off);
    it.length = 16'(len);
    return it;
  endfunction

  function automatic frag_item_t pick_setup();
    frag_item_t it;
    int         roll;
    it = blank_item(frt_pkg::MODE_SETUP);
    roll = $urandom_range(0, 3);
    if (!ledger.size_set) begin
      // Only setups that are refused before the size gets recorded.
      if (!ledger.wide && roll < 2) begin
        it.size_m1 = $urandom_range(32'h0001_0000, 32'hffff_ffff);
      end else begin
        it.empty = 1'b1;
        it.size_m1 = $urandom_range(1, 32'hffff_ffff);
      end
    end else begin
      case (roll)
        0: begin
          it.empty = 1'b0;
          it.size_m1 = (ledger.obj_size == 0) ? 32'd0 : 32'(ledger.obj_size - 1);
        end
        1: begin
          it.empty = 1'b1;
          it.size_m1 = '0;
        end
        2: begin
          it.empty = 1'b1;
          it.size_m1 = $urandom_range(1, 32'hffff_ffff);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic frag_item_t next_item();
    frag_item_t it;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return pick_fragment();
    it = blank_item(frt_pkg::MODE_DATA);
    if (roll < 85) begin
      it.length = '0;
    end else if (roll < 91) begin
      it.mode = ($urandom_range(0, 1) == 0) ? MODE_RESERVED_A : MODE_RESERVED_B;
    end else begin
      it = pick_setup();
    end
    return it;
  endfunction

  task automatic send_item(frag_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    frag_offset_i <= it.offset;
    frag_length_i <= it.length;
    size_minus_one_i <= it.size_m1;
    empty_object_i <= it.empty;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_item(it);
  endtask

  task automatic idle_in(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_wide(bit value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wide_offsets_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.wide = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int count, bit quiet);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) tx_gap_pct = ($urandom_range(0, 1) == 0) ? 0 : 25;
      if (!quiet && $urandom_range(0, 99) < tx_gap_pct) idle_in($urandom_range(1, 12));
      send_item(next_item());
    end
  endtask

  initial begin
    longint unsigned top_end;
    frag_item_t      first;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wide_offsets_i = 1'b0;
    in_valid_i = 1'b0;
    mode_i = frt_pkg::MODE_SETUP;
    frag_offset_i = '0;
    frag_length_i = '0;
    size_minus_one_i = '0;
    empty_object_i = 1'b0;
    tx_gap_pct = 0;
    rx_steady = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_wide(1'b0);
    // A clean stretch first: insertions, a fragment inside held data, a trim,
    // an adjacent join, an absorb of two intervals and a bridge to offset 0.
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd100, 16'd50, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd300, 16'd20, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd0, 16'd10, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd120, 16'd10, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd140, 16'd30, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd170, 16'd5, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd90, 16'd240, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd10, 16'd80, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'h0000_ffff, 16'd1, '0, 1'b0));
    // Error cases; the first one fails the object for good.
    send_item(spec_item(frt_pkg::MODE_DATA, 32'd500, 16'd0, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'h0000_ffff, 16'd2, '0, 1'b0));
    send_item(spec_item(MODE_RESERVED_A, 32'd0, 16'd1, '0, 1'b0));
    send_item(spec_item(MODE_RESERVED_B, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b1));
    send_item(spec_item(frt_pkg::MODE_SETUP, '0, '0, 32'h0001_0000, 1'b0));
    send_item(spec_item(frt_pkg::MODE_SETUP, '0, '0, 32'd1, 1'b1));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'hffff_ffff, 16'hffff, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_SETUP, '0, '0, 32'hffff_ffff, 1'b1));
    run_random(450, 1'b0);
    settle();

    write_wide(1'b1);
    send_item(spec_item(frt_pkg::MODE_DATA, 32'hffff_ffff, 16'd1, '0, 1'b0));
    send_item(spec_item(frt_pkg::MODE_DATA, 32'hffff_ffff, 16'd2, '0, 1'b0));
    run_random(450, 1'b0);
    settle();

    write_wide(1'b0);
    run_random(250, 1'b0);
    settle();

    write_wide(1'b1);
    top_end = (ledger.held > 0) ? ledger.run_hi[ledger.held - 1] : 0;
    first = blank_item(frt_pkg::MODE_SETUP);
    first.empty = 1'b0;
    if (top_end >= 2 && $urandom_range(0, 1) == 1) begin
      // Declared size ends one byte short of the held data.
      first.size_m1 = 32'(top_end - 2);
    end else if (top_end == 0) begin
      first.size_m1 = $urandom_range(0, 65535);
    end else begin
      top_end = top_end - 1 + $urandom_range(0, 4096);
      first.size_m1 = (top_end > 32'hffff_ffff) ? 32'hffff_ffff : 32'(top_end);
    end
    send_item(first);
    run_random(250, 1'b0);
    settle();

    write_wide(1'b0);
    rx_steady = 1'b1;
    run_random(200, 1'b1);
    settle();

    if (ledger.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/frt_pkg.sv
sv/frt_mem.sv
sv/frt_cmp.sv
sv/fragment_reassembly_tracker.sv
sim/fragment_reassembly_tracker_test.sv
